/* src/byte_taint_shadow_bitmap_assert.svh */
// Assertion macros used by the port-level checker of the taint shadow bitmap.
`ifndef BYTE_TAINT_SHADOW_BITMAP_ASSERT_SVH
`define BYTE_TAINT_SHADOW_BITMAP_ASSERT_SVH

// Checked only while out of reset.
`define BTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define BTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bts_pkg.sv */
// Shared constants and types of the taint shadow bitmap.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int BTS_ADDR_BITS = 16;
  localparam int ADDR_W        = 16;
  localparam int LEN_W         = 13;
  localparam int OP_W          = 2;

  localparam logic [LEN_W-1:0] PAGE_BYTES = 13'h1000;

  localparam logic [OP_W-1:0] OP_TAINT   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // Bit mask and byte count for one shadow byte of a range walk.
  typedef struct packed {
    logic [7:0] mask;
    logic [3:0] step;
  } bts_span_t;

endpackage

/* src/bts_span.sv */
// Span unit: bit mask and byte count covered in the current shadow byte.
`timescale 1ns / 1ps

module bts_span
  import bts_pkg::*;
(
  input  logic [2:0]       offset,
  input  logic [LEN_W-1:0] remain,
  output bts_span_t        span
);

  logic [3:0] avail;
  logic [3:0] step;
  logic [8:0] ones;

  always_comb begin
    avail = 4'd8 - {1'b0, offset};
    if (remain < LEN_W'(avail)) begin
      step = remain[3:0];
    end else begin
      step = avail;
    end
    ones      = (9'd1 << step) - 9'd1;
    span.step = step;
    span.mask = ones[7:0] << offset;
  end

endmodule

/* src/bts_shadow_ram.sv */
// Single-port shadow store, one byte per entry, registered read.
`timescale 1ns / 1ps

module bts_shadow_ram
  import bts_pkg::*;
#(
  parameter int DEPTH_BITS = BTS_ADDR_BITS - 3
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [DEPTH_BITS-1:0] addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rdata
);

  logic [7:0] mem [2**DEPTH_BITS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* src/byte_taint_shadow_bitmap.sv */
// Byte-granular taint shadow bitmap: top level with the walk sequencer.
//
// Input channel (in_*): one request per transfer. in_tuser carries the
// operation (taint, release, query, none), in_tdata the start address and the
// byte length (1 to 4096, larger values saturate to 4096, zero is empty).
// Output channel (out_*): exactly one result per request, in order;
// out_tdata[0] is the query hit bit, zero for the other operations.
// The range is walked one shadow byte at a time: a read state and a
// modify/write state on the single store port. A range of one to eight
// bytes touches one or two shadow bytes. A query stops at the first
// tainted byte. in_tready is high only while idle. After reset the
// store is cleared by a sweep over all 2^(ADDR_BITS-3) entries (8192
// at the default), during which in_tready stays low.
// A result waits in the output register while the receiver stalls; the
// next request is still taken and walked, and its result waits for the
// output register to empty.
`timescale 1ns / 1ps

module byte_taint_shadow_bitmap
  import bts_pkg::*;
#(
  parameter int ADDR_BITS = BTS_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] address, [28:16] length, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] any_tainted, rest zero
);

  localparam int DW = ADDR_BITS - 3;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic                 hit_r, hit_nxt;
  logic [DW-1:0]        clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_any_r, out_any_nxt;

  logic [ADDR_W-1:0]    in_address;
  logic [LEN_W-1:0]     in_length;
  logic [LEN_W-1:0]     len_sat;
  logic                 mem_we;
  logic [DW-1:0]        mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  bts_span_t            span;

  assign in_address = in_tdata[ADDR_W-1:0];
  assign in_length  = in_tdata[ADDR_W+LEN_W-1:ADDR_W];
  assign len_sat    = (in_length > PAGE_BYTES) ? PAGE_BYTES : in_length;

  bts_span u_span (
    .offset (addr_r[2:0]),
    .remain (rem_r),
    .span   (span)
  );

  bts_shadow_ram #(
    .DEPTH_BITS (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    op_nxt        = op_r;
    hit_nxt       = hit_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_any_nxt   = out_any_r;
    mem_we        = 1'b0;
    mem_addr      = addr_r[ADDR_BITS-1:3];
    mem_wdata     = 8'd0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + DW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          addr_nxt = ADDR_BITS'(in_address);
          rem_nxt  = len_sat;
          hit_nxt  = 1'b0;
          if (in_tuser == OP_NONE || len_sat == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        addr_nxt = addr_r + ADDR_BITS'(span.step);
        rem_nxt  = rem_r - LEN_W'(span.step);
        if (op_r == OP_QUERY) begin
          if ((mem_rdata & span.mask) != 8'd0) begin
            hit_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (rem_nxt == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          mem_we = 1'b1;
          if (op_r == OP_TAINT) begin
            mem_wdata = mem_rdata | span.mask;
          end else begin
            mem_wdata = mem_rdata & ~span.mask;
          end
          if (rem_nxt == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_any_nxt   = hit_r && (op_r == OP_QUERY);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    rem_r     <= rem_nxt;
    op_r      <= op_nxt;
    hit_r     <= hit_nxt;
    out_any_r <= out_any_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_any_r};

endmodule

/* src/bts_checker.sv */
// Port-level checker for the taint shadow bitmap, bound to the top level.
`timescale 1ns / 1ps
`include "byte_taint_shadow_bitmap_assert.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // Requests accepted whose result has not been transferred yet.
  logic [1:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  `BTS_ASSERT_ALWAYS(a_reset_blocks, clk, !rst_n |=> (!in_tready && !out_tvalid), "ports live after reset")
  `BTS_ASSERT(a_busy_after_take, clk, rst_n, in_xfer |=> !in_tready, "request taken while walking")
  `BTS_ASSERT(a_no_spurious_out, clk, rst_n, out_tvalid |-> (pend_r != 2'd0), "result without request")
  `BTS_ASSERT(a_ready_bound, clk, rst_n, in_tready |-> (pend_r != 2'd2), "too many requests in flight")
  `BTS_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

endmodule

bind byte_taint_shadow_bitmap bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/taint_shadow_checker.sv */
// Checker for the taint shadow bitmap: tracks the shadow store and compares every result.
`timescale 1ns / 1ps

module taint_shadow_checker
  import bts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int SHADOW_DEPTH = (1 << BTS_ADDR_BITS) >> 3;

  // one bit per byte address: bit b of entry k is byte 8*k + b
  logic [7:0] shadow_bytes [0:SHADOW_DEPTH-1];
  logic [7:0] expected_hits [$];

  // Applies one request to the shadow copy and returns its any_tainted bit.
  function automatic logic walk_shadow_range(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] start,
                                             input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] span;
    logic [ADDR_W-1:0] a;
    logic hit;
    int i;
    span = (len > PAGE_BYTES) ? PAGE_BYTES : len;
    if (op == OP_NONE)
      span = '0;
    hit = 1'b0;
    for (i = 0; i < span; i++) begin
      a = start + ADDR_W'(i);   // wraps at the region end
      case (op)
        OP_TAINT:   shadow_bytes[a[ADDR_W-1:3]][a[2:0]] = 1'b1;
        OP_RELEASE: shadow_bytes[a[ADDR_W-1:3]][a[2:0]] = 1'b0;
        default: begin
          if (shadow_bytes[a[ADDR_W-1:3]][a[2:0]])
            hit = 1'b1;
        end
      endcase
      if (hit)
        break;
    end
    return (op == OP_QUERY) ? hit : 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] want;
    int k;
    if (!rst_n) begin
      fail_count = 0;
      expected_hits.delete();
      for (k = 0; k < SHADOW_DEPTH; k++)
        shadow_bytes[k] = 8'h00;
    end else begin
      // results first: a request accepted on this edge cannot have answered yet
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: any_tainted mismatch, expected %h, actual %h",
                     $time, want, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_hits.push_back({7'b0, walk_shadow_range(in_tuser, in_tdata[15:0],
                                                         in_tdata[28:16])});
    end
    pending = expected_hits.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for the taint shadow bitmap: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import bts_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 40000;  // clear sweep + full-page walk + stalls, with margin
  localparam int DRAIN_CYCLES = 1200;   // longest walk is a full page
  localparam int MAX_STALL    = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_TAINT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  int fail_count;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  logic [15:0] hot_base = 16'h4000;

  logic [15:0] ready_pattern = 16'hFFFF;
  int pattern_left = 0;
  int stall_run = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_taint_shadow_bitmap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  taint_shadow_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver back-pressure: rotating pattern, reloaded at random when pattern_left runs out
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom);
      endcase
      pattern_left = 48;
    end
    pattern_left--;
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    if (!ready_pattern[0] && stall_run < MAX_STALL) begin
      out_tready <= 1'b0;
      stall_run++;
    end else begin
      out_tready <= 1'b1;
      stall_run = 0;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                              input logic [12:0] len);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, len, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly short ranges, a few full pages, saturated and zero lengths
  function automatic logic [12:0] pick_length();
    int roll;
    roll = $urandom_range(0, 999);
    if (roll < 10)
      return 13'd0;
    else if (roll < 18)
      return 13'($urandom_range(4097, 8191));
    else if (roll < 40)
      return 13'($urandom_range(1000, 4096));
    else if (roll < 150)
      return 13'($urandom_range(17, 300));
    else
      return 13'($urandom_range(1, 16));
  endfunction

  // taint a range, probe around it, maybe release part of it, probe again
  task automatic run_sequence();
    logic [15:0] base;
    logic [12:0] len;
    int roll;
    if ($urandom_range(0, 19) == 0)
      hot_base = 16'($urandom);
    roll = $urandom_range(0, 9);
    if (roll == 0)
      base = 16'($urandom_range(16'hFF00, 16'hFFFF));   // near the wrap
    else if (roll < 7)
      base = hot_base + 16'($urandom_range(0, 255));
    else
      base = 16'($urandom);
    len = pick_length();
    send_request(OP_TAINT, base, len);
    send_request(OP_QUERY, base + 16'($urandom_range(0, 15)) - 16'd8, pick_length());
    send_request(OP_QUERY, base + 16'(len), pick_length());
    if ($urandom_range(0, 4) < 3)
      send_request(OP_RELEASE, base - 16'($urandom_range(0, 7)), pick_length());
    send_request(OP_QUERY, base - 16'($urandom_range(0, 8)), pick_length());
  endtask

  initial begin : stimulus
    logic mid_pause_done;
    mid_pause_done = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, wrap, zero length, saturation, unused code
    send_request(OP_QUERY,   16'h0000, 13'd1);
    send_request(OP_TAINT,   16'h0000, 13'd1);
    send_request(OP_QUERY,   16'h0000, 13'd1);
    send_request(OP_QUERY,   16'h0001, 13'h1000);
    send_request(OP_TAINT,   16'hFFFF, 13'd2);
    send_request(OP_QUERY,   16'hFFFE, 13'd1);
    send_request(OP_QUERY,   16'hFFF0, 13'h0020);
    send_request(OP_TAINT,   16'h1234, 13'd0);
    send_request(OP_QUERY,   16'h1234, 13'd1);
    send_request(OP_TAINT,   16'h2000, 13'h1FFF);
    send_request(OP_QUERY,   16'h3000, 13'd1);
    send_request(OP_QUERY,   16'h2FFF, 13'd1);
    send_request(OP_RELEASE, 16'h2800, 13'h1000);
    send_request(OP_QUERY,   16'h27FF, 13'd2);
    send_request(OP_QUERY,   16'h2800, 13'h1000);
    send_request(OP_NONE,    16'h0000, 13'd100);
    send_request(OP_QUERY,   16'h0000, 13'd1);
    send_request(OP_RELEASE, 16'h5000, 13'd16);
    send_request(OP_RELEASE, 16'hFFFF, 13'd2);
    send_request(OP_QUERY,   16'hFFFF, 13'd2);
    send_request(OP_TAINT,   16'hAAAA, 13'h1001);
    send_request(OP_QUERY,   16'h5555, 13'h1FFF);
    send_request(OP_QUERY,   16'hBAA9, 13'd1);
    send_request(OP_RELEASE, 16'hAAAA, 13'h1000);
    send_request(OP_QUERY,   16'hAAAA, 13'h1FFF);
    wait_all_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        send_request(2'($urandom_range(0, 3)), 16'($urandom), pick_length());
      else
        run_sequence();
      if (!mid_pause_done && items_sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        mid_pause_done = 1'b1;
      end
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* byte_taint_shadow_bitmap.f */
+incdir+src
src/bts_pkg.sv
src/bts_span.sv
src/bts_shadow_ram.sv
src/byte_taint_shadow_bitmap.sv
src/bts_checker.sv
sim/taint_shadow_checker.sv
sim/tb.sv
